### rtl/core/pfe_pkg.sv
// ---------------------------------------------------------------------------
// pfe_pkg : Playfair pair encryptor shared definitions
// Letter codes, ASCII constants and the small helpers for case folding and
// key-square row/column arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    typedef logic [4:0] t_letter;   // letter index 0..25
    typedef logic [4:0] t_cell;     // square cell 0..24
    typedef logic [2:0] t_coord;    // row or column 0..4

    typedef struct packed {
        logic    ok;
        t_letter idx;
    } t_ltr;

    localparam int unsigned SQ_SIDE  = 5;
    localparam int unsigned SQ_CELLS = 25;
    localparam int unsigned ALPHA    = 26;

    localparam t_letter LTR_I = 5'd8;
    localparam t_letter LTR_J = 5'd9;

    localparam logic [7:0] CHR_UC_A = 8'h41;
    localparam logic [7:0] CHR_UC_Z = 8'h5A;
    localparam logic [7:0] CHR_LC_A = 8'h61;
    localparam logic [7:0] CHR_LC_Z = 8'h7A;
    localparam logic [7:0] CHR_X    = 8'h58;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [6:0] OUT_A = 7'h41;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_KEY   = 2'd1;
    localparam logic [1:0] OP_ENC   = 2'd2;

    localparam logic [ALPHA-1:0] USED_RESET = 26'd1 << LTR_J;

    // only a..z fold
    function automatic logic [7:0] pfe_fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHR_LC_A && c <= CHR_LC_Z) begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

    // letter index of an already folded byte
    function automatic t_ltr pfe_letter(input logic [7:0] c);
        t_ltr       r;
        logic [7:0] d;
        d     = c - CHR_UC_A;
        r.ok  = (c >= CHR_UC_A) && (c <= CHR_UC_Z);
        r.idx = d[4:0];
        return r;
    endfunction

    function automatic t_coord pfe_row(input t_cell p);
        t_coord r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic t_cell pfe_row_base(input t_coord row);
        t_cell b;
        b = {row[2:0], 2'b00} + {2'b00, row};
        return b;
    endfunction

    function automatic t_coord pfe_col(input t_cell p);
        t_cell c;
        c = p - pfe_row_base(pfe_row(p));
        return c[2:0];
    endfunction

    function automatic t_coord pfe_wrap_inc(input t_coord v);
        t_coord r;
        r = (v == t_coord'(SQ_SIDE - 1)) ? 3'd0 : v + 3'd1;
        return r;
    endfunction

    function automatic t_cell pfe_cell(input t_coord row, input t_coord col);
        t_cell r;
        r = pfe_row_base(row) + {2'b00, col};
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/playfair_pair_encryptor_top.sv
// ---------------------------------------------------------------------------
// playfair_pair_encryptor_top : Playfair key-square builder and pair encryptor
// Holds a 5x5 key square, builds it from key bytes and encrypts letter pairs.
// ---------------------------------------------------------------------------
// Usage
//   Input word (i_valid/o_ready): i_op selects clear key, key byte or encrypt
//   pair. A clear or key word is taken without leaving idle and gives no output word.
//   An encrypt word gives one output word (o_valid/i_ready) with the two
//   cipher letters in upper-case ASCII, or zeros with o_bad_input set when a
//   pair letter is not alphabetic. Op code 3 is swallowed without effect.
//   An encrypt on a finished square passes a position read, a square read
//   and an output load before o_valid shows. The first encrypt after a clear
//   first walks all 26 letters, one per cycle, to finish the square. o_ready
//   is low throughout an encrypt, so the next word is not taken until the
//   encrypt has passed the two dependent memory reads and the output load.
//   The output register lets the next word be taken while a result waits;
//   a further encrypt parks in its output step until i_ready frees the
//   register. Reset empties the output register and clears the key; square
//   and position memories are left as they are and rewritten before use.
// ---------------------------------------------------------------------------
`default_nettype none

module playfair_pair_encryptor_top
    import pfe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_first_char,
    input  wire logic [7:0] i_second_char,
    input  wire logic       i_second_present,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [6:0]      o_cipher_first,
    output logic [6:0]      o_cipher_second,
    output logic            o_bad_input
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;   // finish the square, one letter a cycle
    localparam logic [2:0] ST_RD   = 3'd2;   // position lookup
    localparam logic [2:0] ST_SQ   = 3'd3;   // square lookup
    localparam logic [2:0] ST_OUT  = 3'd4;   // load output register

    // sequencer and key state
    logic [2:0]       r_state, n_state;
    t_letter          r_idx, n_idx;
    logic [ALPHA-1:0] r_used, n_used;
    logic [4:0]       r_fill, n_fill;
    logic             r_complete, n_complete;

    // memories
    t_letter r_square [SQ_CELLS];
    t_cell   r_pos    [ALPHA];

    // pair under work
    t_letter r_a, r_b;
    logic    r_bad;
    t_cell   r_p1, r_p2;
    t_letter r_q1, r_q2;

    // output register
    logic       r_out_valid;
    logic [6:0] r_out_first, r_out_second;
    logic       r_out_bad;

    logic       in_acc;
    logic       out_load;
    logic       wr_en;
    t_letter    wr_ltr;
    t_ltr       key_ltr;
    logic [7:0] fa, fb;
    t_ltr       la, lb;
    t_letter    ia, ib;

    t_coord r1, c1, r2, c2;
    t_cell  o1, o2;

    assign o_ready  = (r_state == ST_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_ready);

    // pair front end: fold, pad with X, equal pair turns second into X
    always_comb begin
        fa = pfe_fold(i_first_char);
        fb = i_second_present ? pfe_fold(i_second_char) : CHR_X;
        if (fa == fb) begin
            fb = CHR_X;
        end
        la = pfe_letter(fa);
        lb = pfe_letter(fb);
        ia = (la.idx == LTR_J) ? LTR_I : la.idx;
        ib = (lb.idx == LTR_J) ? LTR_I : lb.idx;
    end

    assign key_ltr = pfe_letter(pfe_fold(i_first_char));

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_used     = r_used;
        n_fill     = r_fill;
        n_complete = r_complete;
        wr_en      = 1'b0;
        wr_ltr     = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_op)
                        OP_CLEAR: begin
                            n_used     = USED_RESET;
                            n_fill     = 5'd0;
                            n_complete = 1'b0;
                        end
                        OP_KEY: begin
                            wr_ltr = key_ltr.idx;
                            wr_en  = !r_complete && key_ltr.ok && !r_used[key_ltr.idx]
                                     && (r_fill < 5'(SQ_CELLS));
                        end
                        OP_ENC: begin
                            n_idx   = 5'd0;
                            n_state = r_complete ? ST_RD : ST_FILL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                wr_en = !r_used[r_idx] && (r_fill < 5'(SQ_CELLS));
                if (r_idx == 5'(ALPHA - 1)) begin
                    n_complete = 1'b1;
                    n_state    = ST_RD;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            ST_RD:  n_state = ST_SQ;
            ST_SQ:  n_state = ST_OUT;
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (wr_en) begin
            n_used[wr_ltr] = 1'b1;
            n_fill         = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= 5'd0;
            r_used     <= USED_RESET;
            r_fill     <= 5'd0;
            r_complete <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_used     <= n_used;
            r_fill     <= n_fill;
            r_complete <= n_complete;
        end
    end

    // square and position memories share one write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_square[r_fill] <= wr_ltr;
            r_pos[wr_ltr]    <= r_fill;
        end
    end

    // latch the pair on acceptance
    always_ff @(posedge i_clk) begin
        if (in_acc && i_op == OP_ENC) begin
            r_a   <= ia;
            r_b   <= ib;
            r_bad <= !la.ok || !lb.ok;
        end
    end

    // cipher cell selection from the two positions
    always_comb begin
        r1 = pfe_row(r_p1);
        c1 = pfe_col(r_p1);
        r2 = pfe_row(r_p2);
        c2 = pfe_col(r_p2);
        if (r1 == r2) begin
            o1 = pfe_cell(r1, pfe_wrap_inc(c1));
            o2 = pfe_cell(r2, pfe_wrap_inc(c2));
        end else if (c1 == c2) begin
            o1 = pfe_cell(pfe_wrap_inc(r1), c1);
            o2 = pfe_cell(pfe_wrap_inc(r2), c2);
        end else begin
            o1 = pfe_cell(r1, c2);
            o2 = pfe_cell(r2, c1);
        end
    end

    // registered reads: positions in ST_RD, square cells in ST_SQ
    always_ff @(posedge i_clk) begin
        r_p1 <= r_pos[r_a];
        r_p2 <= r_pos[r_b];
        r_q1 <= r_square[o1];
        r_q2 <= r_square[o2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_bad    <= r_bad;
            r_out_first  <= r_bad ? 7'd0 : OUT_A + {2'b00, r_q1};
            r_out_second <= r_bad ? 7'd0 : OUT_A + {2'b00, r_q2};
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cipher_first  = r_out_first;
    assign o_cipher_second = r_out_second;
    assign o_bad_input     = r_out_bad;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'(SQ_CELLS))
        else $error("fill count past square size");

    a_complete_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> (r_fill == 5'(SQ_CELLS)) && (&r_used))
        else $error("completed square not full");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_input) |-> (o_cipher_first == 7'd0 && o_cipher_second == 7'd0))
        else $error("error word carries letters");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_bad_input) |->
            (o_cipher_first >= 7'h41 && o_cipher_first <= 7'h5A && o_cipher_first != 7'h4A
             && o_cipher_second >= 7'h41 && o_cipher_second <= 7'h5A
             && o_cipher_second != 7'h4A))
        else $error("cipher letter out of range");

    a_no_key_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_complete && r_state == ST_IDLE) |-> !wr_en)
        else $error("key write after square completion");

endmodule

`default_nettype wire
